// ----- hw/rtl/urtb_pkg.sv -----
// Shared types, constants and pointer helpers for the UART receive and transmit ring buffers.
package urtb_pkg;

	localparam int RX_DEPTH = 32;
	localparam int TX_DEPTH = 32;
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int DATA_W = 8;
	localparam int STATUS_W = 4;
	localparam int COUNT_W = 5;
	localparam int CMD_W = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_LINE_RX    = 3'd0,
		CMD_TX_READY   = 3'd1,
		CMD_HOST_READ  = 3'd2,
		CMD_HOST_WRITE = 3'd3,
		CMD_FLUSH_RX   = 3'd4
	} cmd_t;

	typedef struct packed {
		logic              we;
		logic [RX_AW-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [RX_AW-1:0]  raddr;
	} rx_ram_req_t;

	typedef struct packed {
		logic              we;
		logic [TX_AW-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [TX_AW-1:0]  raddr;
	} tx_ram_req_t;

	typedef struct packed {
		logic                done;
		logic                read_valid;
		logic                line_valid;
		logic                write_refused;
		logic [COUNT_W-1:0]  rx_count;
		logic [STATUS_W-1:0] last_error;
		logic                overflow_seen;
	} result_t;

	function automatic logic [RX_AW-1:0] rx_adv(input logic [RX_AW-1:0] p);
		return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [TX_AW-1:0] tx_adv(input logic [TX_AW-1:0] p);
		return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

// ----- hw/rtl/urtb_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module urtb_ram #(
	parameter int Width = 8,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/urtb_ctrl.sv -----
// Ring pointer, flag and result control for the receive and transmit rings.
module urtb_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [urtb_pkg::CMD_W-1:0]     cmd,
	input  logic [urtb_pkg::DATA_W-1:0]    byte_in,
	input  logic [urtb_pkg::STATUS_W-1:0]  line_status,
	output urtb_pkg::rx_ram_req_t          rx_req,
	output urtb_pkg::tx_ram_req_t          tx_req,
	output urtb_pkg::result_t              res
);

	localparam int RxCw = urtb_pkg::RX_AW + 1;

	logic [urtb_pkg::RX_AW-1:0]    rx_wp_q, rx_rp_q, rx_wp_d, rx_rp_d, rx_wnext;
	logic [urtb_pkg::TX_AW-1:0]    tx_wp_q, tx_rp_q, tx_wp_d, tx_rp_d, tx_wnext;
	logic [urtb_pkg::STATUS_W-1:0] err_q, err_d;
	logic                          ovf_q, ovf_d;
	logic                          rd_valid_d, ln_valid_d, refused_d;
	logic [RxCw-1:0]               cnt_d;

	logic                          done_s1, rd_valid_s1, ln_valid_s1, refused_s1;
	logic [urtb_pkg::COUNT_W-1:0]  count_s1;

	assign rx_wnext = urtb_pkg::rx_adv(rx_wp_q);
	assign tx_wnext = urtb_pkg::tx_adv(tx_wp_q);

	always_comb begin
		rx_wp_d    = rx_wp_q;
		rx_rp_d    = rx_rp_q;
		tx_wp_d    = tx_wp_q;
		tx_rp_d    = tx_rp_q;
		err_d      = err_q;
		ovf_d      = ovf_q;
		rd_valid_d = 1'b0;
		ln_valid_d = 1'b0;
		refused_d  = 1'b0;
		rx_req     = '0;
		tx_req     = '0;
		rx_req.wdata = byte_in;
		tx_req.wdata = byte_in;
		if (accept) begin
			unique case (cmd)
				urtb_pkg::CMD_LINE_RX: begin
					// A full ring drops the byte but still captures its status.
					if (rx_wnext == rx_rp_q) begin
						ovf_d = 1'b1;
					end else begin
						rx_wp_d      = rx_wnext;
						rx_req.we    = 1'b1;
						rx_req.waddr = rx_wnext;
						ovf_d        = 1'b0;
					end
					err_d = line_status;
				end
				urtb_pkg::CMD_TX_READY: begin
					if (tx_wp_q != tx_rp_q) begin
						tx_rp_d      = urtb_pkg::tx_adv(tx_rp_q);
						tx_req.re    = 1'b1;
						tx_req.raddr = tx_rp_d;
						ln_valid_d   = 1'b1;
					end
				end
				urtb_pkg::CMD_HOST_READ: begin
					if (rx_wp_q != rx_rp_q) begin
						rx_rp_d      = urtb_pkg::rx_adv(rx_rp_q);
						rx_req.re    = 1'b1;
						rx_req.raddr = rx_rp_d;
						rd_valid_d   = 1'b1;
					end
				end
				urtb_pkg::CMD_HOST_WRITE: begin
					if (tx_wnext == tx_rp_q) begin
						refused_d = 1'b1;
					end else begin
						tx_wp_d      = tx_wnext;
						tx_req.we    = 1'b1;
						tx_req.waddr = tx_wnext;
					end
				end
				urtb_pkg::CMD_FLUSH_RX: begin
					rx_wp_d = rx_rp_q;
				end
				default: begin
				end
			endcase
		end
		// Occupancy after the event, modulo the ring depth.
		if (rx_wp_d >= rx_rp_d) begin
			cnt_d = RxCw'(rx_wp_d - rx_rp_d);
		end else begin
			cnt_d = RxCw'(urtb_pkg::RX_DEPTH) - RxCw'(rx_rp_d) + RxCw'(rx_wp_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_wp_q     <= '0;
			rx_rp_q     <= '0;
			tx_wp_q     <= '0;
			tx_rp_q     <= '0;
			err_q       <= '0;
			ovf_q       <= 1'b0;
			done_s1     <= 1'b0;
			rd_valid_s1 <= 1'b0;
			ln_valid_s1 <= 1'b0;
			refused_s1  <= 1'b0;
			count_s1    <= '0;
		end else begin
			rx_wp_q     <= rx_wp_d;
			rx_rp_q     <= rx_rp_d;
			tx_wp_q     <= tx_wp_d;
			tx_rp_q     <= tx_rp_d;
			err_q       <= err_d;
			ovf_q       <= ovf_d;
			done_s1     <= accept;
			rd_valid_s1 <= rd_valid_d;
			ln_valid_s1 <= ln_valid_d;
			refused_s1  <= refused_d;
			count_s1    <= urtb_pkg::COUNT_W'(cnt_d);
		end
	end

	assign res.done          = done_s1;
	assign res.read_valid    = rd_valid_s1;
	assign res.line_valid    = ln_valid_s1;
	assign res.write_refused = refused_s1;
	assign res.rx_count      = count_s1;
	assign res.last_error    = err_q;
	assign res.overflow_seen = ovf_q;

	// A single event touches at most one of the result flags.
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({rd_valid_s1, ln_valid_s1, refused_s1}))
		else $error("more than one result flag set");

	// Every accepted event yields exactly one result in the next cycle.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done_s1)
		else $error("accepted event produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done_s1)
		else $error("result without an accepted event");

	// A flush leaves the receive ring empty.
	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == urtb_pkg::CMD_FLUSH_RX |=> rx_wp_q == rx_rp_q && count_s1 == '0)
		else $error("receive ring not empty after flush");

	// The receive memory is never written and read in the same cycle.
	a_rx_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(rx_req.we && rx_req.re))
		else $error("receive ring read and written together");

endmodule

// ----- hw/rtl/uart_rx_tx_ring_buffers.sv -----
// Top level of the UART receive and transmit ring buffers with event command port.
// Latency: a word accepted at a clock edge yields its result, marked by done, in the next
// cycle; the popped byte comes straight from the registered read port of its ring memory.
// Throughput: one word per cycle; pointers update at the accepting edge, so a following
// event already sees them. busy is high only in the first cycle after reset.
// Reset clears both ring pointers, the error capture and the overflow flag; the ring memories
// are not cleared and their contents are only read after being written.
module uart_rx_tx_ring_buffers (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [urtb_pkg::CMD_W-1:0]    cmd,
	input  logic [urtb_pkg::DATA_W-1:0]   byte_in,
	input  logic [urtb_pkg::STATUS_W-1:0] line_status,
	output logic                          done,
	output logic [urtb_pkg::DATA_W-1:0]   read_data,
	output logic                          read_valid,
	output logic [urtb_pkg::DATA_W-1:0]   line_data,
	output logic                          line_valid,
	output logic                          write_refused,
	output logic [urtb_pkg::COUNT_W-1:0]  rx_count,
	output logic [urtb_pkg::STATUS_W-1:0] last_error,
	output logic                          overflow_seen
);

	urtb_pkg::rx_ram_req_t        rx_req;
	urtb_pkg::tx_ram_req_t        tx_req;
	urtb_pkg::result_t            res;
	logic [urtb_pkg::DATA_W-1:0]  rx_rdata, tx_rdata;
	logic                         busy_q;
	logic                         accept;

	// The block holds off the first cycle out of reset, then takes a word every cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	// Pointer and flag control: decides each event and drives both ring memories.
	urtb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cmd         (cmd),
		.byte_in     (byte_in),
		.line_status (line_status),
		.rx_req      (rx_req),
		.tx_req      (tx_req),
		.res         (res)
	);

	// Receive ring storage: written by line receives, read by host reads.
	urtb_ram #(
		.Width (urtb_pkg::DATA_W),
		.Depth (urtb_pkg::RX_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (rx_req.we),
		.waddr (rx_req.waddr),
		.wdata (rx_req.wdata),
		.re    (rx_req.re),
		.raddr (rx_req.raddr),
		.rdata (rx_rdata)
	);

	// Transmit ring storage: written by host writes, read when the transmitter is ready.
	urtb_ram #(
		.Width (urtb_pkg::DATA_W),
		.Depth (urtb_pkg::TX_DEPTH)
	) u_tx_ram (
		.clk   (clk),
		.we    (tx_req.we),
		.waddr (tx_req.waddr),
		.wdata (tx_req.wdata),
		.re    (tx_req.re),
		.raddr (tx_req.raddr),
		.rdata (tx_rdata)
	);

	// Data fields read as zero unless the event actually popped a byte.
	assign done          = res.done;
	assign read_valid    = res.read_valid;
	assign read_data     = res.read_valid ? rx_rdata : '0;
	assign line_valid    = res.line_valid;
	assign line_data     = res.line_valid ? tx_rdata : '0;
	assign write_refused = res.write_refused;
	assign rx_count      = res.rx_count;
	assign last_error    = res.last_error;
	assign overflow_seen = res.overflow_seen;

endmodule
